// ----- rtl/iasp_pkg.sv -----
// shared types and constants for the indexed animation stream parser
`default_nettype none
package iasp_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC = 4'd0,
      PH_COUNT = 4'd1,
      PH_DEPTH = 4'd2,
      PH_TABLE = 4'd3,
      PH_HOT   = 4'd4,
      PH_FLAG  = 4'd5,
      PH_TRANS = 4'd6,
      PH_PAL   = 4'd7,
      PH_PIXEL = 4'd8,
      PH_TRAIL = 4'd9,
      PH_DEAD  = 4'd10
   } phase_type;

   localparam logic [3:0] KIND_MAGIC   = 4'd0;
   localparam logic [3:0] KIND_COUNT   = 4'd1;
   localparam logic [3:0] KIND_DEPTH   = 4'd2;
   localparam logic [3:0] KIND_WIDTH   = 4'd3;
   localparam logic [3:0] KIND_HEIGHT  = 4'd4;
   localparam logic [3:0] KIND_HOTX    = 4'd5;
   localparam logic [3:0] KIND_HOTY    = 4'd6;
   localparam logic [3:0] KIND_PALFLAG = 4'd7;
   localparam logic [3:0] KIND_TRANS   = 4'd8;
   localparam logic [3:0] KIND_PALETTE = 4'd9;
   localparam logic [3:0] KIND_PIXEL   = 4'd10;
   localparam logic [3:0] KIND_EXTRA   = 4'd11;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FORMAT = 3'd1;
   localparam logic [2:0] ST_TOO_SMALL  = 3'd2;
   localparam logic [2:0] ST_EXTRA      = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_BAD_DEPTH  = 3'd5;

   localparam logic [5:0] PAL_LAST = 6'd47;
   localparam logic [7:0] MAX_BPP  = 8'd8;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0: r = 8'h49;
         2'd1: r = 8'h41;
         2'd2: r = 8'h4E;
         default: r = 8'h4D;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/iasp_stream_if.sv -----
// request and response channel interfaces
`default_nettype none
interface iasp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;
   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface iasp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [15:0] frame_number;
   logic [15:0] field_value;
   logic        field_complete;
   logic [1:0]  palette_number;
   logic [31:0] entry_offset;
   logic        frame_has_palette;
   logic [15:0] palette_frame;
   logic [2:0]  status;
   logic        parse_done;
   modport source (output valid, output kind, output frame_number, output field_value,
                   output field_complete, output palette_number, output entry_offset,
                   output frame_has_palette, output palette_frame, output status,
                   output parse_done, input ready);
   modport sink (input valid, input kind, input frame_number, input field_value,
                 input field_complete, input palette_number, input entry_offset,
                 input frame_has_palette, input palette_frame, input status,
                 input parse_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/indexed_animation_stream_parser.sv -----
// top level of the indexed animation stream parser
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    data_byte, end_of_file
//  rsp_ch    out  valid/ready    kind .. parse_done, one item per byte
//
// one byte per cycle while results are taken; each byte's result is registered and shown in the cycle after acceptance
// the size table read and pixel count multiply run during the hotspot bytes
// synchronous reset returns to the magic word; an end of file byte does too
// a stalled result holds the input off only while it is not being taken
`default_nettype none
module indexed_animation_stream_parser #(
   parameter int MAX_FRAMES = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   iasp_req_if.sink   req_ch,
   iasp_rsp_if.source rsp_ch
);

   localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   logic          wr_en;
   logic [AW-1:0] mem_addr;
   logic [31:0]   wr_data;
   logic [3:0]    bpp;
   logic [31:0]   pixel_count;

   iasp_parser #(.MAX_FRAMES(MAX_FRAMES), .AW(AW)) u_parser (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .wr_en(wr_en),
      .mem_addr(mem_addr),
      .wr_data(wr_data),
      .bpp(bpp),
      .pixel_count(pixel_count)
   );

   iasp_size_mem #(.AW(AW)) u_size_mem (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(mem_addr),
      .wr_data(wr_data),
      .rd_addr(mem_addr),
      .bpp(bpp),
      .pixel_count(pixel_count)
   );

   a_dead_has_status: assert property (@(posedge clock) disable iff (reset)
      u_parser.phase_ff == iasp_pkg::PH_DEAD |-> u_parser.err_ff != iasp_pkg::ST_OK)
      else $error("dead parser without status");

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.end_of_file
      |=> u_parser.phase_ff == iasp_pkg::PH_MAGIC && u_parser.cf_ff == 16'd0)
      else $error("end of file did not restart parse");

   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.parse_done
      |-> rsp_ch.kind == iasp_pkg::KIND_DEPTH || rsp_ch.kind == iasp_pkg::KIND_TRANS
          || rsp_ch.kind == iasp_pkg::KIND_PALETTE || rsp_ch.kind == iasp_pkg::KIND_PIXEL)
      else $error("parse done on wrong item kind");

endmodule
`default_nettype wire

// ----- rtl/iasp_size_mem.sv -----
// frame size memory with pixel byte count pipeline
`default_nettype none
module iasp_size_mem #(
   parameter int AW = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic [3:0]    bpp,
   output logic [31:0]        pixel_count
);

   logic [31:0] mem [2**AW];
   logic [31:0] rd_ff;
   logic [31:0] count_ff;
   logic [31:0] count_in;
   logic [1:0]  shift_c;
   logic [16:0] cols_c;
   logic [32:0] prod_c;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (bpp)
         4'd1: shift_c = 2'd3;
         4'd2: shift_c = 2'd2;
         4'd3, 4'd4: shift_c = 2'd1;
         default: shift_c = 2'd0;
      endcase
      cols_c = ({1'b0, rd_ff[31:16]} + ((17'd1 << shift_c) - 17'd1)) >> shift_c;
      prod_c = cols_c * {17'd0, rd_ff[15:0]};
      count_in = prod_c[31:0];
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign pixel_count = count_ff;

endmodule
`default_nettype wire

// ----- rtl/iasp_parser.sv -----
// byte labelling sequencer with result register
`default_nettype none
module iasp_parser #(
   parameter int MAX_FRAMES = 256,
   parameter int AW = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   iasp_req_if.sink    req_ch,
   iasp_rsp_if.source  rsp_ch,
   output logic          wr_en,
   output logic [AW-1:0] mem_addr,
   output logic [31:0]   wr_data,
   output logic [3:0]    bpp,
   input  wire logic [31:0] pixel_count
);

   iasp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  bif_ff, bif_in;
   logic [15:0] total_ff, total_in;
   logic [3:0]  bpp_ff, bpp_in;
   logic [15:0] cf_ff, cf_in;
   logic [15:0] acc_ff, acc_in;
   logic [15:0] width_ff, width_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] idx_ff, idx_in;
   logic [15:0] ipf_ff, ipf_in;
   logic        ipv_ff, ipv_in;
   logic [2:0]  err_ff, err_in;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] shifted;
   logic [15:0] cf_next;
   logic        ef_done;

   logic [3:0]  kind_c;
   logic [15:0] fnum_c;
   logic [15:0] value_c;
   logic        comp_c;
   logic [1:0]  paln_c;
   logic [31:0] off_c;
   logic        show_c;
   logic        done_c;

   logic        valid_ff;
   logic [3:0]  kind_ff;
   logic [15:0] fnum_ff;
   logic [15:0] value_ff;
   logic        comp_ff;
   logic [1:0]  paln_ff;
   logic [31:0] off_ff;
   logic        hasp_ff;
   logic [15:0] palf_ff;
   logic [2:0]  stat_ff;
   logic        done_ff;

   assign req_ch.ready = !valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign b = req_ch.data_byte;
   assign shifted = {acc_ff[7:0], b};
   assign cf_next = cf_ff + 16'd1;
   assign ef_done = cf_next >= total_ff;

   assign mem_addr = ({1'b0, cf_ff} < 17'(MAX_FRAMES)) ? cf_ff[AW-1:0] : '0;
   assign wr_data = {width_ff, shifted};
   assign bpp = bpp_ff;

   always_comb begin
      phase_in = phase_ff;
      bif_in = bif_ff;
      total_in = total_ff;
      bpp_in = bpp_ff;
      cf_in = cf_ff;
      acc_in = acc_ff;
      width_in = width_ff;
      left_in = left_ff;
      idx_in = idx_ff;
      ipf_in = ipf_ff;
      ipv_in = ipv_ff;
      err_in = err_ff;
      wr_en = 1'b0;
      kind_c = iasp_pkg::KIND_EXTRA;
      fnum_c = '0;
      value_c = {8'd0, b};
      comp_c = 1'b1;
      paln_c = '0;
      off_c = '0;
      show_c = 1'b0;
      done_c = 1'b0;
      case (phase_ff)
         iasp_pkg::PH_MAGIC: begin
            kind_c = iasp_pkg::KIND_MAGIC;
            value_c = shifted;
            acc_in = shifted;
            comp_c = (bif_ff == 2'd3);
            if (b != iasp_pkg::magic_byte(bif_ff)) begin
               err_in = iasp_pkg::ST_NOT_FORMAT;
               phase_in = iasp_pkg::PH_DEAD;
            end else if (bif_ff == 2'd3) begin
               bif_in = '0;
               acc_in = '0;
               phase_in = iasp_pkg::PH_COUNT;
            end else begin
               bif_in = bif_ff + 2'd1;
            end
         end
         iasp_pkg::PH_COUNT: begin
            kind_c = iasp_pkg::KIND_COUNT;
            value_c = shifted;
            acc_in = shifted;
            comp_c = (bif_ff != 2'd0);
            if (bif_ff != 2'd0) begin
               total_in = shifted;
               acc_in = '0;
               bif_in = '0;
               if ({1'b0, shifted} > 17'(MAX_FRAMES)) begin
                  err_in = iasp_pkg::ST_TABLE_FULL;
                  phase_in = iasp_pkg::PH_DEAD;
               end else begin
                  phase_in = iasp_pkg::PH_DEPTH;
               end
            end else begin
               bif_in = 2'd1;
            end
         end
         iasp_pkg::PH_DEPTH: begin
            kind_c = iasp_pkg::KIND_DEPTH;
            value_c = shifted;
            acc_in = shifted;
            comp_c = (bif_ff != 2'd0);
            if (bif_ff != 2'd0) begin
               bpp_in = b[3:0];
               acc_in = '0;
               bif_in = '0;
               cf_in = '0;
               if (total_ff == 16'd0) begin
                  done_c = 1'b1;
                  phase_in = iasp_pkg::PH_TRAIL;
               end else if (b == 8'd0 || b > iasp_pkg::MAX_BPP) begin
                  err_in = iasp_pkg::ST_BAD_DEPTH;
                  phase_in = iasp_pkg::PH_DEAD;
               end else begin
                  phase_in = iasp_pkg::PH_TABLE;
               end
            end else begin
               bif_in = 2'd1;
            end
         end
         iasp_pkg::PH_TABLE: begin
            kind_c = (bif_ff < 2'd2) ? iasp_pkg::KIND_WIDTH : iasp_pkg::KIND_HEIGHT;
            fnum_c = cf_ff;
            value_c = shifted;
            acc_in = shifted;
            comp_c = (bif_ff == 2'd1 || bif_ff == 2'd3);
            bif_in = bif_ff + 2'd1;
            if (bif_ff == 2'd1) begin
               width_in = shifted;
               acc_in = '0;
            end else if (bif_ff == 2'd3) begin
               wr_en = 1'b1;
               acc_in = '0;
               if (ef_done) begin
                  cf_in = '0;
                  phase_in = iasp_pkg::PH_HOT;
               end else begin
                  cf_in = cf_next;
               end
            end
         end
         iasp_pkg::PH_HOT: begin
            kind_c = (bif_ff < 2'd2) ? iasp_pkg::KIND_HOTX : iasp_pkg::KIND_HOTY;
            fnum_c = cf_ff;
            value_c = shifted;
            comp_c = (bif_ff == 2'd1 || bif_ff == 2'd3);
            acc_in = comp_c ? 16'd0 : shifted;
            bif_in = bif_ff + 2'd1;
            if (bif_ff == 2'd3) begin
               phase_in = iasp_pkg::PH_FLAG;
            end
         end
         iasp_pkg::PH_FLAG: begin
            kind_c = iasp_pkg::KIND_PALFLAG;
            fnum_c = cf_ff;
            show_c = 1'b1;
            if (b != 8'd0) begin
               ipf_in = cf_ff;
               ipv_in = 1'b1;
            end else if (cf_ff == 16'd0) begin
               ipf_in = '0;
               ipv_in = 1'b0;
            end
            phase_in = iasp_pkg::PH_TRANS;
         end
         iasp_pkg::PH_TRANS: begin
            kind_c = iasp_pkg::KIND_TRANS;
            fnum_c = cf_ff;
            value_c = {12'd0, b[3:0]};
            show_c = 1'b1;
            left_in = pixel_count;
            idx_in = '0;
            if (ipv_ff && ipf_ff == cf_ff) begin
               phase_in = iasp_pkg::PH_PAL;
            end else if (pixel_count == 32'd0) begin
               cf_in = cf_next;
               bif_in = '0;
               done_c = ef_done;
               phase_in = ef_done ? iasp_pkg::PH_TRAIL : iasp_pkg::PH_HOT;
            end else begin
               phase_in = iasp_pkg::PH_PIXEL;
            end
         end
         iasp_pkg::PH_PAL: begin
            kind_c = iasp_pkg::KIND_PALETTE;
            fnum_c = cf_ff;
            show_c = 1'b1;
            paln_c = idx_ff[5:4];
            off_c = {28'd0, idx_ff[3:0]};
            idx_in = idx_ff + 32'd1;
            if (idx_ff[5:0] == iasp_pkg::PAL_LAST) begin
               idx_in = '0;
               if (left_ff == 32'd0) begin
                  cf_in = cf_next;
                  bif_in = '0;
                  done_c = ef_done;
                  phase_in = ef_done ? iasp_pkg::PH_TRAIL : iasp_pkg::PH_HOT;
               end else begin
                  phase_in = iasp_pkg::PH_PIXEL;
               end
            end
         end
         iasp_pkg::PH_PIXEL: begin
            kind_c = iasp_pkg::KIND_PIXEL;
            fnum_c = cf_ff;
            show_c = 1'b1;
            off_c = idx_ff;
            idx_in = idx_ff + 32'd1;
            if (left_ff != 32'd0) begin
               left_in = left_ff - 32'd1;
            end
            if (left_ff <= 32'd1) begin
               cf_in = cf_next;
               bif_in = '0;
               done_c = ef_done;
               phase_in = ef_done ? iasp_pkg::PH_TRAIL : iasp_pkg::PH_HOT;
            end
         end
         iasp_pkg::PH_TRAIL: begin
            if (err_ff == iasp_pkg::ST_OK) begin
               err_in = iasp_pkg::ST_EXTRA;
            end
         end
         default: begin
            phase_in = iasp_pkg::PH_DEAD;
         end
      endcase

      if (req_ch.end_of_file && phase_in != iasp_pkg::PH_TRAIL
          && phase_in != iasp_pkg::PH_DEAD && err_in == iasp_pkg::ST_OK) begin
         err_in = (phase_in <= iasp_pkg::PH_DEPTH) ? iasp_pkg::ST_NOT_FORMAT
                                                   : iasp_pkg::ST_TOO_SMALL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= iasp_pkg::PH_MAGIC;
         bif_ff <= '0;
         total_ff <= '0;
         bpp_ff <= '0;
         cf_ff <= '0;
         acc_ff <= '0;
         left_ff <= '0;
         idx_ff <= '0;
         ipf_ff <= '0;
         ipv_ff <= 1'b0;
         err_ff <= '0;
      end else if (accept) begin
         if (req_ch.end_of_file) begin
            phase_ff <= iasp_pkg::PH_MAGIC;
            bif_ff <= '0;
            total_ff <= '0;
            bpp_ff <= '0;
            cf_ff <= '0;
            acc_ff <= '0;
            left_ff <= '0;
            idx_ff <= '0;
            ipf_ff <= '0;
            ipv_ff <= 1'b0;
            err_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            bif_ff <= bif_in;
            total_ff <= total_in;
            bpp_ff <= bpp_in;
            cf_ff <= cf_in;
            acc_ff <= acc_in;
            left_ff <= left_in;
            idx_ff <= idx_in;
            ipf_ff <= ipf_in;
            ipv_ff <= ipv_in;
            err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_c;
         fnum_ff <= fnum_c;
         value_ff <= value_c;
         comp_ff <= comp_c;
         paln_ff <= paln_c;
         off_ff <= off_c;
         hasp_ff <= show_c && ipv_in;
         palf_ff <= (show_c && ipv_in) ? ipf_in : 16'd0;
         stat_ff <= err_in;
         done_ff <= done_c;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.kind = kind_ff;
   assign rsp_ch.frame_number = fnum_ff;
   assign rsp_ch.field_value = value_ff;
   assign rsp_ch.field_complete = comp_ff;
   assign rsp_ch.palette_number = paln_ff;
   assign rsp_ch.entry_offset = off_ff;
   assign rsp_ch.frame_has_palette = hasp_ff;
   assign rsp_ch.palette_frame = palf_ff;
   assign rsp_ch.status = stat_ff;
   assign rsp_ch.parse_done = done_ff;

endmodule
`default_nettype wire

// ----- tb/sv/tb_indexed_animation_stream_parser.sv -----
// self-checking testbench for the indexed animation stream parser
module tb_indexed_animation_stream_parser;

   localparam int IDLE_LIMIT = 4000;
   localparam int TABLE_SLOTS = 256;
   localparam int MAX_COUNT = 256;
   localparam int RANDOM_ITEMS = 600;
   localparam int LARGE_FILE_BYTES = 200;
   localparam logic [7:0] SIG_BYTES [4] = '{8'h49, 8'h41, 8'h4E, 8'h4D};

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] frame_number;
      logic [15:0] field_value;
      logic        field_complete;
      logic [1:0]  palette_number;
      logic [31:0] entry_offset;
      logic        frame_has_palette;
      logic [15:0] palette_frame;
      logic [2:0]  status;
      logic        parse_done;
   } byte_label_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iasp_req_if req_ch ();
   iasp_rsp_if rsp_ch ();

   indexed_animation_stream_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // parser state as seen by the predictor
   iasp_pkg::phase_type ph;
   logic [3:0]  field_pos;
   logic [15:0] n_frames;
   logic [7:0]  depth_bpp;
   logic [15:0] frame_idx;
   logic [15:0] acc;
   logic [31:0] frame_dims [TABLE_SLOTS];
   logic [31:0] px_left;
   logic [31:0] px_idx;
   logic [15:0] pal_src;
   logic        pal_ok;
   logic [2:0]  err_code;

   byte_label_type expected_labels [$];
   logic [7:0]  file_q [$];
   int          n_sent;
   int          n_checked;
   int          n_mismatch;
   int          n_files;
   int          idle_cycles;
   int          status_seen [6];
   bit          no_idle;
   bit          hold_request;
   int          hold_count;
   int          stall_left;

   task automatic clear_parser();
      ph = iasp_pkg::PH_MAGIC;
      field_pos = '0;
      n_frames = '0;
      depth_bpp = '0;
      frame_idx = '0;
      acc = '0;
      px_left = '0;
      px_idx = '0;
      pal_src = '0;
      pal_ok = 1'b0;
      err_code = iasp_pkg::ST_OK;
   endtask

   function automatic logic [31:0] pixel_bytes_of(logic [31:0] dims, logic [7:0] bpp);
      logic [31:0] w, h, per;
      w = dims >> 16;
      h = dims & 32'hffff;
      if (bpp == 0 || bpp > iasp_pkg::MAX_BPP) return 0;
      per = 8 / bpp;
      return ((w + per - 1) / per) * h;
   endfunction

   function automatic int slot_of(logic [15:0] f);
      return (f < TABLE_SLOTS) ? int'(f) : 0;
   endfunction

   task automatic close_frame(inout logic done);
      frame_idx = frame_idx + 16'd1;
      field_pos = '0;
      if (frame_idx >= n_frames) begin
         done = 1'b1;
         ph = iasp_pkg::PH_TRAIL;
      end else begin
         ph = iasp_pkg::PH_HOT;
      end
   endtask

   task automatic label_byte(input logic [7:0] b, input logic eof);
      byte_label_type r;
      logic [15:0] cf;
      logic        show;
      logic        done;
      logic        last;
      r = '0;
      r.kind = iasp_pkg::KIND_EXTRA;
      r.field_value = {8'h00, b};
      r.field_complete = 1'b1;
      cf = frame_idx;
      show = 1'b0;
      done = 1'b0;
      case (ph)
         iasp_pkg::PH_MAGIC: begin
            r.kind = iasp_pkg::KIND_MAGIC;
            acc = {acc[7:0], b};
            r.field_value = acc;
            last = (field_pos >= 3);
            r.field_complete = last;
            if (b != SIG_BYTES[field_pos[1:0]]) begin
               err_code = iasp_pkg::ST_NOT_FORMAT;
               ph = iasp_pkg::PH_DEAD;
            end else if (last) begin
               field_pos = '0;
               acc = '0;
               ph = iasp_pkg::PH_COUNT;
            end else begin
               field_pos++;
            end
         end
         iasp_pkg::PH_COUNT, iasp_pkg::PH_DEPTH: begin
            r.kind = (ph == iasp_pkg::PH_COUNT) ? iasp_pkg::KIND_COUNT : iasp_pkg::KIND_DEPTH;
            acc = {acc[7:0], b};
            r.field_value = acc;
            r.field_complete = (field_pos != 0);
            if (field_pos == 0) begin
               field_pos = 1;
            end else if (ph == iasp_pkg::PH_COUNT) begin
               n_frames = acc;
               acc = '0;
               field_pos = '0;
               if (n_frames > MAX_COUNT) begin
                  err_code = iasp_pkg::ST_TABLE_FULL;
                  ph = iasp_pkg::PH_DEAD;
               end else begin
                  ph = iasp_pkg::PH_DEPTH;
               end
            end else begin
               depth_bpp = b;
               acc = '0;
               field_pos = '0;
               frame_idx = '0;
               if (n_frames == 0) begin
                  done = 1'b1;
                  ph = iasp_pkg::PH_TRAIL;
               end else if (b == 0 || b > iasp_pkg::MAX_BPP) begin
                  err_code = iasp_pkg::ST_BAD_DEPTH;
                  ph = iasp_pkg::PH_DEAD;
               end else begin
                  ph = iasp_pkg::PH_TABLE;
               end
            end
         end
         iasp_pkg::PH_TABLE: begin
            r.kind = (field_pos < 2) ? iasp_pkg::KIND_WIDTH : iasp_pkg::KIND_HEIGHT;
            r.frame_number = cf;
            acc = {acc[7:0], b};
            r.field_value = acc;
            r.field_complete = (field_pos == 1 || field_pos == 3);
            if (field_pos == 1) begin
               frame_dims[slot_of(cf)] = {acc, 16'h0000};
               acc = '0;
            end else if (field_pos == 3) begin
               frame_dims[slot_of(cf)][15:0] = acc;
               acc = '0;
            end
            field_pos++;
            if (field_pos >= 4) begin
               field_pos = '0;
               frame_idx = cf + 16'd1;
               if (frame_idx >= n_frames) begin
                  frame_idx = '0;
                  ph = iasp_pkg::PH_HOT;
               end
            end
         end
         iasp_pkg::PH_HOT: begin
            r.kind = (field_pos < 2) ? iasp_pkg::KIND_HOTX : iasp_pkg::KIND_HOTY;
            r.frame_number = cf;
            acc = {acc[7:0], b};
            r.field_value = acc;
            r.field_complete = (field_pos == 1 || field_pos == 3);
            if (r.field_complete) acc = '0;
            field_pos++;
            if (field_pos >= 4) begin
               field_pos = '0;
               ph = iasp_pkg::PH_FLAG;
            end
         end
         iasp_pkg::PH_FLAG: begin
            r.kind = iasp_pkg::KIND_PALFLAG;
            r.frame_number = cf;
            if (b != 0) begin
               pal_src = cf;
               pal_ok = 1'b1;
            end else if (cf == 0) begin
               pal_src = '0;
               pal_ok = 1'b0;
            end
            show = 1'b1;
            ph = iasp_pkg::PH_TRANS;
         end
         iasp_pkg::PH_TRANS: begin
            r.kind = iasp_pkg::KIND_TRANS;
            r.frame_number = cf;
            r.field_value = {12'h000, b[3:0]};
            show = 1'b1;
            px_left = pixel_bytes_of(frame_dims[slot_of(cf)], depth_bpp);
            px_idx = '0;
            if (pal_ok && pal_src == cf) ph = iasp_pkg::PH_PAL;
            else if (px_left == 0) close_frame(done);
            else ph = iasp_pkg::PH_PIXEL;
         end
         iasp_pkg::PH_PAL: begin
            r.kind = iasp_pkg::KIND_PALETTE;
            r.frame_number = cf;
            show = 1'b1;
            r.palette_number = px_idx[5:4];
            r.entry_offset = {28'h0, px_idx[3:0]};
            px_idx++;
            if (px_idx > iasp_pkg::PAL_LAST) begin
               px_idx = '0;
               if (px_left == 0) close_frame(done);
               else ph = iasp_pkg::PH_PIXEL;
            end
         end
         iasp_pkg::PH_PIXEL: begin
            r.kind = iasp_pkg::KIND_PIXEL;
            r.frame_number = cf;
            show = 1'b1;
            r.entry_offset = px_idx;
            px_idx++;
            if (px_left != 0) px_left--;
            if (px_left == 0) close_frame(done);
         end
         iasp_pkg::PH_TRAIL: begin
            if (err_code == iasp_pkg::ST_OK) err_code = iasp_pkg::ST_EXTRA;
         end
         default: ph = iasp_pkg::PH_DEAD;
      endcase
      if (eof && ph != iasp_pkg::PH_TRAIL && ph != iasp_pkg::PH_DEAD
          && err_code == iasp_pkg::ST_OK)
         err_code = (ph <= iasp_pkg::PH_DEPTH) ? iasp_pkg::ST_NOT_FORMAT
                                               : iasp_pkg::ST_TOO_SMALL;
      r.frame_has_palette = show & pal_ok;
      r.palette_frame = (show && pal_ok) ? pal_src : 16'h0000;
      r.status = err_code;
      r.parse_done = done;
      expected_labels.push_back(r);
      if (eof) clear_parser();
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // result side: random stalls plus a long hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_count = 300;
         hold_request = 1'b0;
      end
      if (hold_count > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_count--;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
   end

   // sampled mid-cycle, so values are those seen at the next rising edge
   always @(negedge clock) begin
      byte_label_type got;
      byte_label_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.kind, rsp_ch.frame_number, rsp_ch.field_value,
                    rsp_ch.field_complete, rsp_ch.palette_number, rsp_ch.entry_offset,
                    rsp_ch.frame_has_palette, rsp_ch.palette_frame, rsp_ch.status,
                    rsp_ch.parse_done};
            if (got.status <= iasp_pkg::ST_BAD_DEPTH) status_seen[got.status]++;
            if (expected_labels.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected result item: %p", got);
            end else begin
               want = expected_labels.pop_front();
               n_checked++;
               if (got !== want) begin
                  n_mismatch++;
                  if (n_mismatch <= 10) begin
                     $display("mismatch on result %0d", n_checked);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) label_byte(req_ch.data_byte, req_ch.end_of_file);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.end_of_file <= eof;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      n_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
      n_files++;
   endtask

   task automatic build_anim(input int n, input logic [7:0] bpp, input int maxw,
                             input int maxh, input int pal_pct);
      int w [TABLE_SLOTS];
      int h [TABLE_SLOTS];
      int per;
      int cnt;
      logic [7:0] flag;
      file_q.delete();
      foreach (SIG_BYTES[i]) file_q.push_back(SIG_BYTES[i]);
      file_q.push_back(n[15:8]);
      file_q.push_back(n[7:0]);
      file_q.push_back(rand_byte());
      file_q.push_back(bpp);
      for (int i = 0; i < n && i < TABLE_SLOTS; i++) begin
         w[i] = $urandom_range(0, maxw);
         h[i] = $urandom_range(0, maxh);
         file_q.push_back(w[i][15:8]);
         file_q.push_back(w[i][7:0]);
         file_q.push_back(h[i][15:8]);
         file_q.push_back(h[i][7:0]);
      end
      per = (bpp == 0 || bpp > 8) ? 0 : 8 / bpp;
      for (int i = 0; i < n && i < TABLE_SLOTS; i++) begin
         repeat (4) file_q.push_back(rand_byte());
         flag = ($urandom_range(0, 99) < pal_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
         file_q.push_back(flag);
         file_q.push_back(rand_byte());
         if (flag != 0) repeat (48) file_q.push_back(rand_byte());
         cnt = (per == 0) ? 0 : ((w[i] + per - 1) / per) * h[i];
         repeat (cnt) file_q.push_back(rand_byte());
      end
   endtask

   task automatic test_header_errors();
      for (int k = 0; k < 4; k++) begin
         build_anim(1, 8'd4, 3, 2, 0);
         file_q[k] = file_q[k] ^ 8'h20;
         send_file();
      end
      build_anim(1, 8'd1, 2, 2, 0);
      file_q[4] = 8'h01;
      file_q[5] = 8'h01;
      send_file();
      build_anim(1, 8'd1, 2, 2, 0);
      file_q[4] = 8'hff;
      file_q[5] = 8'hff;
      send_file();
      build_anim(2, 8'd0, 2, 2, 0);
      send_file();
      build_anim(2, 8'd9, 2, 2, 0);
      send_file();
      build_anim(2, 8'd255, 2, 2, 0);
      send_file();
   endtask

   task automatic test_zero_frames();
      build_anim(0, 8'd0, 0, 0, 0);
      send_file();
      build_anim(0, 8'd3, 0, 0, 0);
      repeat (3) file_q.push_back(rand_byte());
      send_file();
   endtask

   task automatic test_palettes();
      build_anim(5, 8'd2, 9, 3, 50);
      file_q[$] = 8'hff;
      send_file();
      build_anim(3, 8'd8, 4, 2, 100);
      send_file();
   endtask

   task automatic test_empty_frames();
      build_anim(4, 8'd1, 0, 0, 30);
      send_file();
      build_anim(3, 8'd5, 12, 0, 0);
      send_file();
   endtask

   task automatic test_truncation();
      build_anim(1, 8'd4, 2, 2, 0);
      while (file_q.size() > 5) void'(file_q.pop_back());
      send_file();
      build_anim(3, 8'd4, 6, 3, 40);
      while (file_q.size() > 20) void'(file_q.pop_back());
      send_file();
      build_anim(2, 8'd8, 3, 3, 100);
      void'(file_q.pop_back());
      send_file();
   endtask

   // full frame count accepted, file cut short inside the size table
   task automatic test_largest_table();
      build_anim(MAX_COUNT, 8'd1, 1, 1, 5);
      while (file_q.size() > LARGE_FILE_BYTES) void'(file_q.pop_back());
      send_file();
   endtask

   task automatic test_back_pressure();
      no_idle = 1'b1;
      hold_request = 1'b1;
      build_anim(4, 8'd2, 16, 4, 50);
      send_file();
      no_idle = 1'b0;
   endtask

   task automatic test_random_files();
      int start;
      int mode;
      start = n_sent;
      while (n_sent - start < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 99);
         no_idle = ($urandom_range(0, 9) == 0);
         if (mode < 88)
            build_anim($urandom_range(1, 6), 8'($urandom_range(1, 8)), 10, 4, 40);
         else
            build_anim($urandom_range(0, 3), 8'($urandom_range(0, 255)), 4, 2, 40);
         if (mode >= 70 && mode < 78) begin
            repeat ($urandom_range(1, 12)) if (file_q.size() > 1) void'(file_q.pop_back());
         end else if (mode >= 78 && mode < 86) begin
            repeat ($urandom_range(1, 5)) file_q.push_back(rand_byte());
         end else if (mode >= 86 && mode < 94) begin
            file_q[$urandom_range(0, file_q.size() - 1)] = rand_byte();
         end else if (mode >= 94) begin
            file_q.delete();
            repeat ($urandom_range(1, 10)) file_q.push_back(rand_byte());
         end
         send_file();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int settle;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.end_of_file = 1'b0;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_errors();
      test_zero_frames();
      test_palettes();
      test_empty_frames();
      test_truncation();
      test_largest_table();
      test_back_pressure();
      test_random_files();
      req_ch.valid <= 1'b0;
      settle = 0;
      while (expected_labels.size() != 0 && settle < IDLE_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (10) @(posedge clock);
      $display("%0d files, %0d bytes sent, %0d results checked, %0d mismatches",
               n_files, n_sent, n_checked, n_mismatch);
      $display("status ok %0d, format %0d, short %0d, extra %0d, table %0d, depth %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (n_mismatch == 0 && expected_labels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
